[design/lra_pkg.sv]
// Shared types and constants for the label raster adjacency block.
// No dependencies; imported by every module of the block except lra_ram.
package lra_pkg;

  localparam int LABEL_W   = 4;   // piece label width
  localparam int SIZE_W    = 7;   // size_z register width
  localparam int OUT_DEPTH = 4;   // result queue entries
  localparam int OUT_PTR_W = 2;   // result queue pointer width
  localparam int OUT_CNT_W = 3;   // result queue fill count width

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_CELL  = 1'b1
  } op_t;

  // one grid cell: occupied flag plus label
  typedef struct packed {
    logic               ok;
    logic [LABEL_W-1:0] lab;
  } cell_t;

  localparam cell_t CELL_EMPTY = '{ok: 1'b0, lab: '0};

  // accepted word as seen by the pair stage
  typedef struct packed {
    logic  clr;
    cell_t cur;
    cell_t prev;
    logic  left_ok;
  } front_t;

  // one matrix job: a clear, or a pair lookup (lo < hi)
  typedef struct packed {
    logic               clr;
    logic               pair_first;
    logic [LABEL_W-1:0] lo;
    logic [LABEL_W-1:0] hi;
  } job_t;

  typedef struct packed {
    logic               last;
    logic [LABEL_W-1:0] lo;
    logic [LABEL_W-1:0] hi;
  } res_t;

  function automatic job_t make_pair(cell_t a, cell_t b, logic first);
    job_t j;
    j.clr        = 1'b0;
    j.pair_first = first;
    j.lo         = (a.lab < b.lab) ? a.lab : b.lab;
    j.hi         = (a.lab < b.lab) ? b.lab : a.lab;
    return j;
  endfunction

endpackage

[design/lra_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Read returns the old contents on a same-address write. No dependencies.
module lra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/lra_front.sv]
// Input side: row tracking, previous cell and the column store RAM.
// Depends on lra_pkg and lra_ram.
module lra_front #(
  parameter int PIECES     = 16,
  parameter int MAX_COLUMN = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  lra_pkg::op_t                  op,
  input  logic                          empty_req,
  input  logic [lra_pkg::LABEL_W-1:0]   label,
  input  logic [lra_pkg::SIZE_W-1:0]    size_z,
  output lra_pkg::front_t               b_out,
  output lra_pkg::cell_t                left_rd
);
  import lra_pkg::*;

  localparam int RW = $clog2(MAX_COLUMN);
  localparam int CW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  logic [RW-1:0]         row;
  logic                  first;
  cell_t                 prev;
  logic [MAX_COLUMN-1:0] col_ok;
  cell_t                 cur_cell;
  logic [CW-1:0]         size_eff;
  logic [CW-1:0]         row_inc;
  logic                  col_end;
  logic                  is_cell;

  always_comb begin
    is_cell      = take && (op == OP_CELL);
    cur_cell.ok  = !empty_req && (32'(label) < PIECES);
    cur_cell.lab = label;
    if (size_z == '0) begin
      size_eff = CW'(1);
    end else if (CW'(size_z) > CW'(MAX_COLUMN)) begin
      size_eff = CW'(MAX_COLUMN);
    end else begin
      size_eff = CW'(size_z);
    end
    row_inc = CW'(row) + CW'(1);
    col_end = (row_inc >= size_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      first  <= 1'b1;
      prev   <= CELL_EMPTY;
      col_ok <= '0;
    end else if (take) begin
      if (op == OP_CLEAR) begin
        row    <= '0;
        first  <= 1'b1;
        prev   <= CELL_EMPTY;
        col_ok <= '0;
      end else begin
        col_ok[row] <= 1'b1;
        if (col_end) begin
          row   <= '0;
          first <= 1'b0;
          prev  <= CELL_EMPTY;
        end else begin
          row  <= row_inc[RW-1:0];
          prev <= cur_cell;
        end
      end
    end
  end

  // word handed to the pair stage; left label arrives from the RAM
  always_ff @(posedge clk) begin
    if (take) begin
      b_out.clr     <= (op == OP_CLEAR);
      b_out.cur     <= cur_cell;
      b_out.prev    <= prev;
      b_out.left_ok <= !first && col_ok[row];
    end
  end

  lra_ram #(
    .WIDTH ($bits(cell_t)),
    .DEPTH (MAX_COLUMN)
  ) u_col_ram (
    .clk   (clk),
    .we    (is_cell),
    .waddr (row),
    .wdata (cur_cell),
    .re    (is_cell),
    .raddr (row),
    .rdata (left_rd)
  );

endmodule

[design/lra_adj.sv]
// Pair split, adjacency matrix read-modify-write and last-flag fixup.
// Depends on lra_pkg and lra_ram.
module lra_adj #(
  parameter int PIECES = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           take,
  input  lra_pkg::front_t                b_in,
  input  lra_pkg::cell_t                 left_rd,
  input  logic [lra_pkg::OUT_CNT_W-1:0]  out_count,
  output logic                           b_done,
  output logic                           push,
  output lra_pkg::res_t                  push_res
);
  import lra_pkg::*;

  localparam int AW = $clog2(PIECES);
  localparam int UW = OUT_CNT_W + 1;

  // split stage
  logic    b_v;
  logic    sub;
  cell_t   left_c;
  logic    pa;
  logic    pb;
  logic    two;
  logic    need;
  logic    can;
  logic    issue;
  job_t    ja;
  job_t    jb;
  job_t    job_sel;
  logic [UW-1:0] credit_use;

  // matrix stage
  logic              c_v;
  job_t              c_job;
  logic [PIECES-1:0] row_rd;
  logic [PIECES-1:0] row_eff;
  logic [PIECES-1:0] row_new;
  logic [PIECES-1:0] row_ok;
  logic              is_new;
  logic              wr;
  logic              f_v;
  logic [AW-1:0]     f_addr;
  logic [PIECES-1:0] f_data;

  // fixup stage
  logic d_v;
  logic d_new;
  job_t d_job;

  always_comb begin
    left_c = b_in.left_ok ? left_rd : CELL_EMPTY;
    pa = !b_in.clr && b_in.cur.ok && b_in.prev.ok && (b_in.cur.lab != b_in.prev.lab);
    pb = !b_in.clr && b_in.cur.ok && left_c.ok && (b_in.cur.lab != left_c.lab)
         && !(pa && (left_c.lab == b_in.prev.lab));
    two = pa && pb;
    ja  = make_pair(b_in.cur, b_in.prev, two);
    jb  = make_pair(b_in.cur, left_c, 1'b0);
    if (b_in.clr) begin
      job_sel = '{clr: 1'b1, pair_first: 1'b0, lo: '0, hi: '0};
    end else if (pa && !(two && sub)) begin
      job_sel = ja;
    end else begin
      job_sel = jb;
    end
    need = b_v && (b_in.clr || pa || pb);
    // a two-pair cell reserves queue room for both so they issue back to back
    credit_use = UW'(out_count) + UW'(c_v) + UW'(d_v) + ((two && !sub) ? UW'(2) : UW'(1));
    can    = (credit_use <= UW'(OUT_DEPTH));
    issue  = need && can;
    b_done = !b_v || !need || (can && (!two || sub));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
      sub <= 1'b0;
    end else if (take) begin
      b_v <= 1'b1;
      sub <= 1'b0;
    end else if (b_done) begin
      b_v <= 1'b0;
      sub <= 1'b0;
    end else if (issue) begin
      sub <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else begin
      c_v <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      c_job <= job_sel;
    end
  end

  // upper triangle only: row lo holds bit hi
  always_comb begin
    if (f_v && (f_addr == AW'(c_job.lo))) begin
      row_eff = f_data;
    end else if (row_ok[AW'(c_job.lo)]) begin
      row_eff = row_rd;
    end else begin
      row_eff = '0;
    end
    is_new  = !row_eff[AW'(c_job.hi)];
    wr      = c_v && !c_job.clr && is_new;
    row_new = row_eff | ({{(PIECES-1){1'b0}}, 1'b1} << AW'(c_job.hi));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_ok <= '0;
      f_v    <= 1'b0;
    end else begin
      f_v <= wr;
      if (c_v && c_job.clr) begin
        row_ok <= '0;
      end else if (wr) begin
        row_ok[AW'(c_job.lo)] <= 1'b1;
      end
    end
  end

  // write bypass: covers a read issued in the same cycle as this write
  always_ff @(posedge clk) begin
    if (wr) begin
      f_addr <= AW'(c_job.lo);
      f_data <= row_new;
    end
  end

  lra_ram #(
    .WIDTH (PIECES),
    .DEPTH (PIECES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (AW'(c_job.lo)),
    .wdata (row_new),
    .re    (issue),
    .raddr (AW'(job_sel.lo)),
    .rdata (row_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else begin
      d_v <= c_v && !c_job.clr;
    end
  end

  always_ff @(posedge clk) begin
    d_new <= is_new;
    d_job <= c_job;
  end

  // first of two: its partner sits in the matrix stage this cycle
  always_comb begin
    push         = d_v && d_new;
    push_res.lo  = d_job.lo;
    push_res.hi  = d_job.hi;
    push_res.last = d_job.pair_first ? !(c_v && !c_job.clr && is_new) : 1'b1;
  end

endmodule

[design/lra_ofifo.sv]
// Small result queue in front of the output stream.
// Depends on lra_pkg.
module lra_ofifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  lra_pkg::res_t                 push_res,
  input  logic                          m_ready,
  output logic                          m_valid,
  output lra_pkg::res_t                 m_res,
  output logic [lra_pkg::OUT_CNT_W-1:0] count
);
  import lra_pkg::*;

  res_t                 q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wp;
  logic [OUT_PTR_W-1:0] rp;
  logic                 pop;

  always_comb begin
    m_valid = (count != '0);
    m_res   = q[rp];
    pop     = m_valid && m_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + OUT_PTR_W'(1);
      end
      if (pop) begin
        rp <= rp + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= push_res;
    end
  end

endmodule

[design/label_raster_adjacency.sv]
// Label raster adjacency: 4-connected region adjacency over a streamed label grid.
// Depends on lra_pkg, lra_front, lra_adj, lra_ofifo (and lra_ram below them).
//
// Usage:
//   s_axis carries one word per grid cell, column after column, size_z cells
//   per column. tuser is the op: clear or cell. tdata holds empty_req and the
//   label. A clear word wipes the adjacency matrix and restarts at row 0 of
//   a new first column; it produces no result.
//   m_axis carries one word per newly found adjacent pair (smaller label in
//   the low nibble, larger in the high nibble); tlast marks the final pair
//   caused by one cell. A cell yields zero, one or two words.
//   cfg_we/cfg_wdata write size_z (reset 64); write it only while idle.
// Timing:
//   A cell with at most one candidate pair is taken every cycle while the queue
//   has room; a cell with two distinct candidate pairs holds the input until both
//   lookups issue, as the adjacency RAM does one row read-modify-write per cycle.
//   A result is registered through the split, matrix and fixup stages and the
//   result queue before m_axis, the second of two pairs right behind the first.
// Reset and stalls:
//   rst clears positions, column valid bits and matrix row valid bits at once,
//   so no clearing sweep is needed; s_axis_tready is low while rst is high.
//   If m_axis stalls, the 4-word result queue fills: a word that needs a matrix
//   lookup waits (s_axis_tready low) while queued words plus lookups in flight
//   would exceed 4 entries; cell words with no candidate pair still pass.
module label_raster_adjacency #(
  parameter int PIECES     = 16,
  parameter int MAX_COLUMN = 64
) (
  input  logic       clk,
  input  logic       rst,
  // config
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,      // size_z
  // cell stream in
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] empty_req, [4:1] label, [7:5] zero
  input  logic [0:0] s_axis_tuser,   // [0] op
  // pair stream out
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] first_piece, [7:4] second_piece
  output logic       m_axis_tlast
);
  import lra_pkg::*;

  logic [SIZE_W-1:0]    size_z;
  logic                 take;
  logic                 b_done;
  front_t               b_word;
  cell_t                left_rd;
  logic                 push;
  res_t                 push_res;
  res_t                 m_res;
  logic [OUT_CNT_W-1:0] out_count;

  // size_z register
  always_ff @(posedge clk) begin
    if (rst) begin
      size_z <= SIZE_W'(64);
    end else if (cfg_we) begin
      size_z <= cfg_wdata;
    end
  end

  // the pair stage frees up as soon as its current word has been issued
  assign s_axis_tready = b_done && !rst;
  assign take          = s_axis_tvalid && s_axis_tready;

  lra_front #(
    .PIECES     (PIECES),
    .MAX_COLUMN (MAX_COLUMN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .op        (op_t'(s_axis_tuser[0])),
    .empty_req (s_axis_tdata[0]),
    .label     (s_axis_tdata[4:1]),
    .size_z    (size_z),
    .b_out     (b_word),
    .left_rd   (left_rd)
  );

  lra_adj #(
    .PIECES (PIECES)
  ) u_adj (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .b_in      (b_word),
    .left_rd   (left_rd),
    .out_count (out_count),
    .b_done    (b_done),
    .push      (push),
    .push_res  (push_res)
  );

  lra_ofifo u_ofifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .m_ready  (m_axis_tready),
    .m_valid  (m_axis_tvalid),
    .m_res    (m_res),
    .count    (out_count)
  );

  assign m_axis_tdata = {m_res.hi, m_res.lo};
  assign m_axis_tlast = m_res.last;

endmodule
